FILE: rtl/assert_macros.svh
// assertion macros shared by wab_alarm_fsm.sv and weekday_alarm_beeper.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

FILE: rtl/wab_pkg.sv
// types and constants of the weekday alarm beeper
package wab_pkg;

    typedef struct packed {
        logic [2:0] week_day;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic       button;
    } tick_t;

    typedef struct packed {
        logic       buzzer;
        logic [2:0] phase;
        logic       day_ok;
    } result_t;

    typedef struct packed {
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [3:0] day_mode;
        logic       alarm_enabled;
        logic [9:0] beep_half_period;
        logic [6:0] beep_limit;
    } cfg_t;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 10;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_ALARM_HOUR       = 3'd0,
        REG_ALARM_MINUTE     = 3'd1,
        REG_DAY_MODE         = 3'd2,
        REG_ALARM_ENABLED    = 3'd3,
        REG_BEEP_HALF_PERIOD = 3'd4,
        REG_BEEP_LIMIT       = 3'd5
    } reg_index_t;

    localparam logic [3:0] MODE_ALL  = 4'd7;
    localparam logic [3:0] MODE_WORK = 4'd8;
    localparam logic [3:0] MODE_WEND = 4'd9;

    localparam logic [2:0] DAY_SUNDAY   = 3'd0;
    localparam logic [2:0] DAY_SATURDAY = 3'd6;

    localparam logic [3:0] RST_DAY_MODE         = MODE_ALL;
    localparam logic [9:0] RST_BEEP_HALF_PERIOD = 10'd500;
    localparam logic [6:0] RST_BEEP_LIMIT       = 7'd100;

endpackage

FILE: rtl/wab_cfg_regs.sv
// configuration registers of the alarm
module wab_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [wab_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [wab_pkg::CfgDataWidth-1:0]     cfg_data,
    output wab_pkg::cfg_t                        cfg
);
    import wab_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALARM_HOUR:       cfg_next.alarm_hour       = cfg_data[4:0];
                REG_ALARM_MINUTE:     cfg_next.alarm_minute     = cfg_data[5:0];
                REG_DAY_MODE:         cfg_next.day_mode         = cfg_data[3:0];
                REG_ALARM_ENABLED:    cfg_next.alarm_enabled    = cfg_data[0];
                REG_BEEP_HALF_PERIOD: cfg_next.beep_half_period = cfg_data[9:0];
                REG_BEEP_LIMIT:       cfg_next.beep_limit       = cfg_data[6:0];
                // unknown index: write dropped
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_hour       <= '0;
            cfg_reg.alarm_minute     <= '0;
            cfg_reg.day_mode         <= RST_DAY_MODE;
            cfg_reg.alarm_enabled    <= 1'b0;
            cfg_reg.beep_half_period <= RST_BEEP_HALF_PERIOD;
            cfg_reg.beep_limit       <= RST_BEEP_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/wab_alarm_fsm.sv
// alarm phase machine, tone timer and result register
`include "assert_macros.svh"

module wab_alarm_fsm
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  wab_pkg::tick_t    tick,
    input  wab_pkg::cfg_t     cfg,
    output wab_pkg::result_t  result
);
    import wab_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ARMED  = 3'd1,
        PH_ON     = 3'd2,
        PH_OFF    = 3'd3,
        PH_SILENT = 3'd4
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     phase_cur;
    logic [9:0] elapsed_reg;
    logic [9:0] elapsed_next;
    logic [6:0] tone_count_reg;
    logic [6:0] tone_count_next;
    result_t    result_reg;
    result_t    result_next;

    logic        day_ok;
    logic        armed_ok;
    logic [10:0] elapsed_inc;
    logic        half_done;

    always_comb
    begin
        priority if (cfg.day_mode == {1'b0, tick.week_day})
            day_ok = 1'b1;
        else if (cfg.day_mode == MODE_ALL)
            day_ok = 1'b1;
        else if (cfg.day_mode == MODE_WORK)
            day_ok = (tick.week_day != DAY_SUNDAY) && (tick.week_day < DAY_SATURDAY);
        else if (cfg.day_mode == MODE_WEND)
            day_ok = (tick.week_day == DAY_SUNDAY) || (tick.week_day == DAY_SATURDAY);
        else
            day_ok = 1'b0;
    end

    assign armed_ok    = day_ok && cfg.alarm_enabled;
    assign elapsed_inc = {1'b0, elapsed_reg} + 11'd1;
    assign half_done   = elapsed_inc > {1'b0, cfg.beep_half_period};

    always_comb
    begin
        // button overrides whatever phase we were in
        phase_cur       = tick.button ? PH_SILENT : phase_reg;
        phase_next      = phase_cur;
        elapsed_next    = elapsed_reg;
        tone_count_next = tone_count_reg;
        unique case (phase_cur)
            PH_IDLE:
            begin
                if (armed_ok)
                    phase_next = PH_ARMED;
            end
            PH_ARMED:
            begin
                if (!armed_ok)
                begin
                    phase_next = PH_IDLE;
                end
                else if (tick.now_minute == cfg.alarm_minute &&
                         tick.now_hour == cfg.alarm_hour)
                begin
                    tone_count_next = '0;
                    elapsed_next    = '0;
                    phase_next      = PH_ON;
                end
            end
            PH_ON:
            begin
                elapsed_next = half_done ? 10'd0 : elapsed_inc[9:0];
                if (half_done)
                    phase_next = PH_OFF;
            end
            PH_OFF:
            begin
                // tone limit is checked ahead of the timer
                if (tone_count_reg >= cfg.beep_limit)
                begin
                    phase_next = PH_SILENT;
                end
                else
                begin
                    elapsed_next = half_done ? 10'd0 : elapsed_inc[9:0];
                    if (half_done)
                    begin
                        tone_count_next = tone_count_reg + 7'd1;
                        phase_next      = PH_ON;
                    end
                end
            end
            PH_SILENT:
            begin
                if (cfg.alarm_minute != tick.now_minute)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        result_next.buzzer = (phase_next == PH_ON);
        result_next.phase  = phase_next;
        result_next.day_ok = day_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            tone_count_reg <= '0;
            result_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            tone_count_reg <= tone_count_next;
            result_reg     <= result_next;
        end
    end

    assign result = result_reg;

    `ASSERT_NEXT(a_button_silences, clk, rst_n, fire && tick.button, phase_reg == PH_SILENT || phase_reg == PH_IDLE)
    `ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !fire, $stable(phase_reg) && $stable(tone_count_reg) && $stable(elapsed_reg))
    `ASSERT_NEXT(a_idle_step, clk, rst_n, fire && phase_reg == PH_IDLE && !tick.button, phase_reg == PH_IDLE || phase_reg == PH_ARMED)

endmodule

FILE: rtl/weekday_alarm_beeper.sv
// path: an accepted tick item is held in the input reg, then its result is held in the result reg
// throughput: one tick item per cycle while the output does not stall, set by the phase update
// while a finished result waits, one more tick item is taken, then the input stalls
// reset: asynchronous active low, phase idle, timers zero, registers at defaults
// no clearing pass, the block takes items in the first cycle after reset
`include "assert_macros.svh"

module weekday_alarm_beeper
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 tick_valid,
    output logic                                 tick_stall,
    input  wab_pkg::tick_t                       tick,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output wab_pkg::result_t                     result,
    input  logic                                 cfg_we,
    input  logic [wab_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [wab_pkg::CfgDataWidth-1:0]     cfg_data
);
    import wab_pkg::*;

    cfg_t  cfg;
    tick_t tick_reg;
    logic  tick_valid_reg;
    logic  tick_valid_next;
    logic  result_valid_reg;
    logic  result_valid_next;
    logic  advance;
    logic  tick_take;

    wab_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // held item moves on when the result register is free or being emptied
    assign advance    = tick_valid_reg && (!result_valid_reg || !result_stall);
    assign tick_stall = tick_valid_reg && !advance;
    assign tick_take  = tick_valid && !tick_stall;

    always_comb
    begin
        tick_valid_next = tick_valid_reg;
        if (tick_take)
            tick_valid_next = 1'b1;
        else if (advance)
            tick_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tick_valid_reg   <= tick_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
            tick_reg <= tick;
    end

    wab_alarm_fsm u_alarm_fsm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .tick   (tick_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign result_valid = result_valid_reg;

    `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, tick_stall, tick_valid_reg && result_valid_reg && result_stall)
    `ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, result_valid_reg)
    `ASSERT_NEXT(a_take_fills_input, clk, rst_n, tick_take, tick_valid_reg)

endmodule

FILE: tb/sv/alarm_checker.sv
`timescale 1ns / 1ps
// alarm checker: watches the tick, result and register ports, predicts each result, compares
module alarm_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick_valid,
    input  logic                              tick_stall,
    input  wab_pkg::tick_t                    tick,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  wab_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [wab_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [wab_pkg::CfgDataWidth-1:0]  cfg_data,
    output int                                pending,
    output int                                failures,
    output int                                checked
);
    import wab_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ARMED  = 3'd1;
    localparam logic [2:0] PH_ON     = 3'd2;
    localparam logic [2:0] PH_OFF    = 3'd3;
    localparam logic [2:0] PH_SILENT = 3'd4;

    cfg_t       alarm_cfg;
    logic [2:0] phase_q;
    logic [9:0] elapsed_q;
    logic [6:0] tones_q;
    result_t    alarm_outputs_due[$];

    function automatic logic day_matches(logic [2:0] wd);
        if (alarm_cfg.day_mode == {1'b0, wd})
            return 1'b1;
        unique case (alarm_cfg.day_mode)
            MODE_ALL:  return 1'b1;
            MODE_WORK: return (wd > DAY_SUNDAY) && (wd < DAY_SATURDAY);
            MODE_WEND: return (wd == DAY_SUNDAY) || (wd == DAY_SATURDAY);
            default:   return 1'b0;
        endcase
    endfunction

    // counts one more tick of the current tone phase, true once the half period is exceeded
    function automatic logic half_period_over();
        logic [10:0] next_count;
        next_count = {1'b0, elapsed_q} + 11'd1;
        if (next_count > {1'b0, alarm_cfg.beep_half_period})
        begin
            elapsed_q = '0;
            return 1'b1;
        end
        elapsed_q = next_count[9:0];
        return 1'b0;
    endfunction

    function automatic result_t next_alarm_output(tick_t t);
        result_t r;
        logic    ok;
        logic    ring_ok;
        ok      = day_matches(t.week_day);
        ring_ok = ok && alarm_cfg.alarm_enabled;
        // the button wins over whatever the phase logic would do
        if (t.button)
            phase_q = PH_SILENT;
        unique case (phase_q)
            PH_IDLE:
                if (ring_ok)
                    phase_q = PH_ARMED;
            PH_ARMED:
                if (!ring_ok)
                    phase_q = PH_IDLE;
                else if (t.now_minute == alarm_cfg.alarm_minute
                         && t.now_hour == alarm_cfg.alarm_hour)
                begin
                    tones_q   = '0;
                    elapsed_q = '0;
                    phase_q   = PH_ON;
                end
            PH_ON:
                if (half_period_over())
                    phase_q = PH_OFF;
            PH_OFF:
                if (tones_q >= alarm_cfg.beep_limit)
                    phase_q = PH_SILENT;
                else if (half_period_over())
                begin
                    tones_q = tones_q + 7'd1;
                    phase_q = PH_ON;
                end
            PH_SILENT:
                if (alarm_cfg.alarm_minute != t.now_minute)
                    phase_q = PH_IDLE;
            default:
                phase_q = PH_IDLE;
        endcase
        r.buzzer = (phase_q == PH_ON);
        r.phase  = phase_q;
        r.day_ok = ok;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t due;
        if (!rst_n)
        begin
            alarm_cfg = '{alarm_hour: '0, alarm_minute: '0, day_mode: RST_DAY_MODE,
                          alarm_enabled: 1'b0, beep_half_period: RST_BEEP_HALF_PERIOD,
                          beep_limit: RST_BEEP_LIMIT};
            phase_q   = PH_IDLE;
            elapsed_q = '0;
            tones_q   = '0;
            alarm_outputs_due.delete();
            pending   = 0;
            failures  = 0;
            checked   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ALARM_HOUR:       alarm_cfg.alarm_hour       = cfg_data[4:0];
                    REG_ALARM_MINUTE:     alarm_cfg.alarm_minute     = cfg_data[5:0];
                    REG_DAY_MODE:         alarm_cfg.day_mode         = cfg_data[3:0];
                    REG_ALARM_ENABLED:    alarm_cfg.alarm_enabled    = cfg_data[0];
                    REG_BEEP_HALF_PERIOD: alarm_cfg.beep_half_period = cfg_data[9:0];
                    REG_BEEP_LIMIT:       alarm_cfg.beep_limit       = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (tick_valid && !tick_stall)
                alarm_outputs_due.push_back(next_alarm_output(tick));
            if (result_valid && !result_stall)
            begin
                if (alarm_outputs_due.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected result item: buzzer %0b phase %0d day_ok %0b",
                                 result.buzzer, result.phase, result.day_ok);
                    failures++;
                end
                else
                begin
                    due = alarm_outputs_due.pop_front();
                    if (due.buzzer !== result.buzzer || due.phase !== result.phase
                        || due.day_ok !== result.day_ok)
                    begin
                        if (failures < 10)
                        begin
                            $display("result %0d mismatch: expected buzzer %0b phase %0d day_ok %0b",
                                     checked, due.buzzer, due.phase, due.day_ok);
                            $display("    got buzzer %0b phase %0d day_ok %0b",
                                     result.buzzer, result.phase, result.day_ok);
                        end
                        failures++;
                    end
                end
                checked++;
            end
            pending = alarm_outputs_due.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, tick and register stimulus, output stalls and verdict
module tb;
    import wab_pkg::*;

    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int SESSION_ITEMS = 100;
    localparam int SESSIONS      = 6;

    localparam logic [2:0] REG_SPARE_LO   = 3'd6;
    localparam logic [2:0] REG_SPARE_HI   = 3'd7;
    localparam logic [3:0] MODE_WEDNESDAY = 4'd3;
    localparam logic [3:0] MODE_BAD_LO    = 4'd12;
    localparam logic [3:0] MODE_BAD_HI    = 4'd15;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     tick_valid;
    logic                     tick_stall;
    tick_t                    tick;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    result_t                  result;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    int pending;
    int failures;
    int checked;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    int n_sent      = 0;
    int n_settings  = 0;

    weekday_alarm_beeper u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    alarm_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .failures     (failures),
        .checked      (checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // output side: random stalls, or a long hold-off whenever the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic tick_t mk_tick(logic [2:0] wd, logic [4:0] hr, logic [5:0] mn,
                                      logic btn);
        return {wd, hr, mn, btn};
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.alarm_hour       = 5'($urandom_range(23));
        c.alarm_minute     = 6'($urandom_range(59));
        c.day_mode         = $urandom_range(1) ? MODE_ALL : 4'($urandom_range(15));
        c.alarm_enabled    = ($urandom_range(9) != 0);
        c.beep_half_period = ($urandom_range(4) == 0) ? 10'($urandom_range(40))
                                                      : 10'($urandom_range(5));
        c.beep_limit       = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                      : 7'($urandom_range(4));
        return c;
    endfunction

    // mostly ticks at the alarm time so the tone sequence runs, then plain times, presses, noise
    function automatic tick_t session_tick(cfg_t c);
        tick_t       t;
        logic [31:0] raw;
        int          pick;
        raw          = $urandom();
        pick         = int'($urandom_range(99));
        t.week_day   = 3'($urandom_range(6));
        t.now_hour   = 5'($urandom_range(23));
        t.now_minute = 6'($urandom_range(59));
        t.button     = ($urandom_range(99) < 3);
        if (pick < 55)
        begin
            t.now_hour   = c.alarm_hour;
            t.now_minute = c.alarm_minute;
        end
        else if (pick < 62)
            t.button = 1'b1;
        else if (pick < 72)
            t = raw[$bits(tick_t)-1:0];
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // waits until every result is out, then rewrites all registers with junk in unused bits
    task automatic apply_settings(input cfg_t c);
        logic [CfgDataWidth-1:0] junk;
        tick_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        junk = CfgDataWidth'($urandom());
        write_reg(REG_ALARM_HOUR, {junk[9:5], c.alarm_hour});
        write_reg(REG_ALARM_MINUTE, {junk[9:6], c.alarm_minute});
        write_reg(REG_DAY_MODE, {junk[9:4], c.day_mode});
        write_reg(REG_ALARM_ENABLED, {junk[9:1], c.alarm_enabled});
        write_reg(REG_BEEP_HALF_PERIOD, c.beep_half_period);
        write_reg(REG_BEEP_LIMIT, {junk[9:7], c.beep_limit});
        write_reg(junk[0] ? REG_SPARE_HI : REG_SPARE_LO, ~junk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        cfg_t c;
        rst_n      = 1'b0;
        tick_valid = 1'b0;
        tick       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 28;
        rx_idle_pct = 75;

        // registers at their reset values
        send_tick(mk_tick(3'd3, 5'd0, 6'd0, 1'b0));

        // short tones: half period zero, one repeat tone
        c = '{alarm_hour: 5'd5, alarm_minute: 6'd30, day_mode: MODE_ALL, alarm_enabled: 1'b1,
              beep_half_period: 10'd0, beep_limit: 7'd1};
        apply_settings(c);
        send_tick(mk_tick(DAY_SUNDAY, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(3'd7, 5'd31, 6'd63, 1'b0));
        repeat (7)
            send_tick(mk_tick(DAY_SATURDAY, 5'd5, 6'd30, 1'b0));
        send_tick(mk_tick(DAY_SATURDAY, 5'd5, 6'd31, 1'b0));
        send_tick(mk_tick(DAY_SATURDAY, 5'd5, 6'd31, 1'b0));
        // press while the minute already differs: silenced and back to idle at once
        send_tick(mk_tick(DAY_SATURDAY, 5'd0, 6'd0, 1'b1));
        // press at the alarm minute stays silenced
        send_tick(mk_tick(DAY_SATURDAY, 5'd5, 6'd30, 1'b1));
        send_tick(mk_tick(DAY_SATURDAY, 5'd5, 6'd29, 1'b0));

        c.day_mode = MODE_WORK;
        apply_settings(c);
        send_tick(mk_tick(DAY_SUNDAY, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(3'd1, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(3'd5, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(DAY_SATURDAY, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(3'd7, 5'd0, 6'd0, 1'b0));

        c.day_mode = MODE_WEND;
        apply_settings(c);
        send_tick(mk_tick(DAY_SUNDAY, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(DAY_SATURDAY, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(3'd3, 5'd0, 6'd0, 1'b0));

        c.day_mode = MODE_WEDNESDAY;
        apply_settings(c);
        send_tick(mk_tick(3'd3, 5'd0, 6'd0, 1'b0));
        send_tick(mk_tick(3'd4, 5'd0, 6'd0, 1'b0));

        // mode out of range: no day qualifies
        c.day_mode = MODE_BAD_LO;
        apply_settings(c);
        send_tick(mk_tick(3'd3, 5'd0, 6'd0, 1'b0));

        for (int prof = 0; prof < 3; prof++)
        begin
            tx_idle_pct = (prof == 0) ? 28 : (prof == 1) ? 75 : 0;
            rx_idle_pct = (prof == 0) ? 75 : (prof == 1) ? 28 : 0;
            for (int sess = 0; sess < SESSIONS; sess++)
            begin
                c = random_settings();
                if (prof == 0 && sess == 0)
                    c = '{alarm_hour: '0, alarm_minute: '0, day_mode: '0, alarm_enabled: 1'b1,
                          beep_half_period: '0, beep_limit: '0};
                else if (prof == 0 && sess == 1)
                    c = '{alarm_hour: 5'd23, alarm_minute: 6'd59, day_mode: MODE_WEND,
                          alarm_enabled: 1'b1, beep_half_period: 10'd1000, beep_limit: 7'd127};
                else if (prof == 1 && sess == 0)
                    c = '{alarm_hour: 5'd31, alarm_minute: 6'd63, day_mode: MODE_BAD_HI,
                          alarm_enabled: 1'b1, beep_half_period: 10'd1023, beep_limit: 7'd127};
                else if (prof == 1 && sess == 1)
                    c.beep_half_period = 10'd1023;
                apply_settings(c);
                // long output hold-off while ticks keep coming, so the input side backs up
                if (prof == 2 && sess == 1)
                    hold_seq <= hold_seq + 1;
                for (int k = 0; k < SESSION_ITEMS; k++)
                    send_tick(session_tick(c));
            end
        end

        tick_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("%0d tick items under %0d register settings, %0d results compared",
                 n_sent, n_settings, checked);
        $display("covered all day modes, tone and silence paths, presses and a long hold-off");
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
